>>> rtl/glyph_bitmap_pixel_expander_core_assert.svh
// Assertion helpers, compiled out for synthesis.
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_CORE_ASSERT_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GBPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbpe assertion failed: same-cycle implication");
// next-cycle implication
`define GBPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbpe assertion failed: next-cycle implication");
`else
`define GBPE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GBPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/gbpe_pkg.sv
package gbpe_pkg;

   localparam int COORD_BITS_DEF = 10;

   // register indexes
   localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_TRANSPARENT   = 3'd1;
   localparam logic [2:0] REG_FG_COLOR      = 3'd2;
   localparam logic [2:0] REG_BG_COLOR      = 3'd3;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

   // reset values
   localparam logic [5:0]  HEIGHT_RST   = 6'd16;
   localparam logic        TRANSP_RST   = 1'b0;
   localparam logic [15:0] FG_RST       = 16'hF800;
   localparam logic [15:0] BG_RST       = 16'hFFFF;
   localparam logic [10:0] SCREEN_W_RST = 11'd240;
   localparam logic [10:0] SCREEN_H_RST = 11'd320;

   localparam logic [5:0] HEIGHT_12 = 6'd12;
   localparam logic [5:0] HEIGHT_16 = 6'd16;
   localparam logic [5:0] HEIGHT_24 = 6'd24;
   localparam logic [5:0] HEIGHT_32 = 6'd32;

   typedef struct packed {
      logic brk;    // byte ends here (column done or glyph stopped)
      logic halt;   // glyph stops here
   } step_flags_type;

   function automatic logic height_ok(input logic [5:0] h);
      return (h == HEIGHT_12) || (h == HEIGHT_16) || (h == HEIGHT_24) || (h == HEIGHT_32);
   endfunction

   // bytes per glyph: ceil(h/8) * h/2
   function automatic logic [6:0] glyph_bytes(input logic [5:0] h);
      logic [6:0] n;
      unique case (h)
         HEIGHT_12: n = 7'd12;
         HEIGHT_16: n = 7'd16;
         HEIGHT_24: n = 7'd36;
         HEIGHT_32: n = 7'd64;
         default:   n = 7'd0;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/glyph_bitmap_pixel_expander_core.sv
// Glyph byte expander: one glyph bit is shifted out and examined per cycle while no
// rsp stall holds it back. A walked byte is accepted, has one to eight bits walked and
// is flushed; a byte of a stopped glyph or bad height is only accepted. A new byte is
// accepted only in idle. A pixel moves to rsp when the next pixel of its byte is found,
// the last one at the flush; each passes the pending register, then the output register.
// Synchronous active-high reset: config to defaults, glyph halted, no pixels.
`include "glyph_bitmap_pixel_expander_core_assert.svh"

module glyph_bitmap_pixel_expander_core #(
   parameter int COORD_BITS = gbpe_pkg::COORD_BITS_DEF,
   localparam int REQ_W = ((2*COORD_BITS + 8 + 7) / 8) * 8,
   localparam int RSP_W = ((2*COORD_BITS + 16 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // origin_x, origin_y, glyph_byte, zero pad
   input  logic             req_tuser,   // glyph_start
   // response stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
   output logic             rsp_tlast,   // last_pixel
   // config writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int CB = COORD_BITS;
   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_type;

   state_type     state_ff, state_in;
   logic          halted_ff, halted_in;
   logic [CB-1:0] cur_col_ff, cur_col_in;
   logic [CB-1:0] cur_row_ff, cur_row_in;
   logic [CB-1:0] top_row_ff, top_row_in;
   logic [6:0]    byte_cnt_ff, byte_cnt_in;
   logic [7:0]    bits_ff, bits_in;
   logic [2:0]    bit_cnt_ff, bit_cnt_in;

   logic          pend_vld_ff, pend_vld_in;
   logic [CB-1:0] pend_x_ff, pend_x_in;
   logic [CB-1:0] pend_y_ff, pend_y_in;
   logic [15:0]   pend_color_ff, pend_color_in;

   logic          rsp_vld_ff, rsp_vld_in;
   logic [CB-1:0] rsp_x_ff, rsp_x_in;
   logic [CB-1:0] rsp_y_ff, rsp_y_in;
   logic [15:0]   rsp_color_ff, rsp_color_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [5:0]    height_ff, height_in;
   logic          transp_ff, transp_in;
   logic [15:0]   fg_ff, fg_in;
   logic [15:0]   bg_ff, bg_in;
   logic [10:0]   scr_w_ff, scr_w_in;
   logic [10:0]   scr_h_ff, scr_h_in;

   logic          req_acc;
   logic          in_start;
   logic [CB-1:0] in_x;
   logic [CB-1:0] in_y;
   logic [7:0]    in_byte;
   logic          h_ok;
   logic          out_free;
   logic          cur_bit;
   logic          emit;
   logic          stall;
   logic          step;
   logic          done;
   logic [6:0]    byte_cnt_inc;
   logic [CB-1:0] nxt_col;
   logic [CB-1:0] nxt_row;
   gbpe_pkg::step_flags_type flags;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign in_start   = req_tuser;
   assign in_x       = req_tdata[CB-1:0];
   assign in_y       = req_tdata[2*CB-1:CB];
   assign in_byte    = req_tdata[2*CB+7:2*CB];

   assign csr_ready  = 1'b1;

   assign h_ok         = gbpe_pkg::height_ok(height_ff);
   assign out_free     = !rsp_vld_ff || rsp_tready;
   assign cur_bit      = bits_ff[7];
   assign emit         = cur_bit || !transp_ff;
   // a new pixel must displace the pending one into the output register
   assign stall        = emit && pend_vld_ff && !out_free;
   assign step         = (state_ff == ST_RUN) && !stall;
   assign done         = step && (flags.brk || (bit_cnt_ff == LAST_BIT));
   assign byte_cnt_inc = byte_cnt_ff + 7'd1;

   gbpe_cursor #(
      .COORD_BITS(COORD_BITS)
   ) u_cursor (
      .cur_col       (cur_col_ff),
      .cur_row       (cur_row_ff),
      .top_row       (top_row_ff),
      .height        (height_ff),
      .screen_width  (scr_w_ff),
      .screen_height (scr_h_ff),
      .next_col      (nxt_col),
      .next_row      (nxt_row),
      .flags         (flags)
   );

   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      top_row_in    = top_row_ff;
      byte_cnt_in   = byte_cnt_ff;
      bits_in       = bits_ff;
      bit_cnt_in    = bit_cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_color_in = pend_color_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               bits_in    = in_byte;
               bit_cnt_in = '0;
               if (in_start) begin
                  cur_col_in  = in_x;
                  cur_row_in  = in_y;
                  top_row_in  = in_y;
                  byte_cnt_in = '0;
                  halted_in   = !h_ok;
               end
               if (h_ok && (in_start || !halted_ff)) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (step) begin
               bits_in    = {bits_ff[6:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 3'd1;
               cur_col_in = nxt_col;
               cur_row_in = nxt_row;
               if (emit) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in   = 1'b1;
                     rsp_x_in     = pend_x_ff;
                     rsp_y_in     = pend_y_ff;
                     rsp_color_in = pend_color_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_vld_in   = 1'b1;
                  pend_x_in     = cur_col_ff;
                  pend_y_in     = cur_row_ff;
                  pend_color_in = cur_bit ? fg_ff : bg_ff;
               end
               if (done) begin
                  state_in = ST_FLUSH;
                  if (flags.halt) begin
                     halted_in = 1'b1;
                  end else begin
                     byte_cnt_in = byte_cnt_inc;
                     if (byte_cnt_inc >= gbpe_pkg::glyph_bytes(height_ff)) begin
                        halted_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            // the held pixel is the last one of this byte
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_color_in = pend_color_ff;
               rsp_last_in  = 1'b1;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      height_in = height_ff;
      transp_in = transp_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      scr_w_in  = scr_w_ff;
      scr_h_in  = scr_h_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gbpe_pkg::REG_GLYPH_HEIGHT:  height_in = csr_data[5:0];
            gbpe_pkg::REG_TRANSPARENT:   transp_in = csr_data[0];
            gbpe_pkg::REG_FG_COLOR:      fg_in     = csr_data;
            gbpe_pkg::REG_BG_COLOR:      bg_in     = csr_data;
            gbpe_pkg::REG_SCREEN_WIDTH:  scr_w_in  = csr_data[10:0];
            gbpe_pkg::REG_SCREEN_HEIGHT: scr_h_in  = csr_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      bits_ff       <= bits_in;
      bit_cnt_ff    <= bit_cnt_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_color_ff <= pend_color_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         halted_ff   <= 1'b1;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         top_row_ff  <= '0;
         byte_cnt_ff <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         height_ff   <= gbpe_pkg::HEIGHT_RST;
         transp_ff   <= gbpe_pkg::TRANSP_RST;
         fg_ff       <= gbpe_pkg::FG_RST;
         bg_ff       <= gbpe_pkg::BG_RST;
         scr_w_ff    <= gbpe_pkg::SCREEN_W_RST;
         scr_h_ff    <= gbpe_pkg::SCREEN_H_RST;
      end else begin
         state_ff    <= state_in;
         halted_ff   <= halted_in;
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         top_row_ff  <= top_row_in;
         byte_cnt_ff <= byte_cnt_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         height_ff   <= height_in;
         transp_ff   <= transp_in;
         fg_ff       <= fg_in;
         bg_ff       <= bg_in;
         scr_w_ff    <= scr_w_in;
         scr_h_ff    <= scr_h_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_W'({rsp_color_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;

   // no pixel left behind once the sequencer is back to idle
   `GBPE_ASSERT_IMPLY(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_vld_ff)
   // bytes of a stopped glyph never start a bit walk
   `GBPE_ASSERT_NEXT(a_halted_no_run, clock, reset, req_acc && !req_tuser && halted_ff,
      state_ff == ST_IDLE)
   // a glyph only stops at the end of a byte
   `GBPE_ASSERT_IMPLY(a_run_not_halted, clock, reset, state_ff == ST_RUN, !halted_ff)

endmodule

>>> rtl/gbpe_cursor.sv
module gbpe_cursor #(
   parameter int COORD_BITS = gbpe_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0] cur_col,
   input  logic [COORD_BITS-1:0] cur_row,
   input  logic [COORD_BITS-1:0] top_row,
   input  logic [5:0]            height,
   input  logic [10:0]           screen_width,
   input  logic [10:0]           screen_height,
   output logic [COORD_BITS-1:0] next_col,
   output logic [COORD_BITS-1:0] next_row,
   output gbpe_pkg::step_flags_type flags
);

   localparam int CW = (COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11;

   logic [CW-1:0] coord_max;
   logic [CW-1:0] nrow;
   logic [CW-1:0] ncol;
   logic [CW-1:0] span;
   logic          row_stop;
   logic          col_stop;
   logic          col_end;

   assign coord_max = {{(CW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
   assign nrow      = CW'(cur_row) + CW'(1);
   assign ncol      = CW'(cur_col) + CW'(1);
   assign span      = nrow - CW'(top_row);

   assign row_stop = (nrow >= CW'(screen_height)) || (nrow > coord_max);
   assign col_stop = (ncol >= CW'(screen_width)) || (ncol > coord_max);
   assign col_end  = span >= CW'(height);

   always_comb begin
      next_row = nrow[COORD_BITS-1:0];
      next_col = cur_col;
      if (!row_stop && col_end) begin
         next_row = top_row;
         next_col = ncol[COORD_BITS-1:0];
      end
   end

   assign flags.brk  = row_stop || col_end;
   assign flags.halt = row_stop || (col_end && col_stop);

endmodule
